// File: rtl/assert_macros.svh
// assertion macros used by the top level of the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked at every rising edge of clk outside reset
`define PTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication, checked at every rising edge of clk outside reset
`define PTS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// File: rtl/pts_pkg.sv
// package: constants, types and tables of the polyphonic triangle synth
package pts_pkg;

  localparam int VOICES   = 8;
  localparam int AUDIO_FS = 22050;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W  = $clog2(VOICES + 1);
  localparam int ACC_W  = 32 + CNT_W;
  localparam int SCALE_SHIFT = 28;

  typedef logic [VIDX_W-1:0] vidx_t;
  localparam vidx_t LAST_VOICE = vidx_t'(VOICES - 1);

  typedef enum logic [1:0] {
    FUNC_NOTE_ON,
    FUNC_NOTE_OFF,
    FUNC_ALL_OFF,
    FUNC_TICK
  } func_t;

  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_RELEASE = 2'd1;
  localparam logic [1:0] REG_GAIN    = 2'd2;

  typedef struct packed {
    logic [6:0]  note;
    logic        gate;
    logic [31:0] phase;
    logic [31:0] step;
    logic [15:0] level;
    logic [15:0] target;
  } voice_t;

  typedef struct packed {
    logic  rd_en;
    vidx_t rd_addr;
    logic  wr_en;
    vidx_t wr_addr;
  } mem_req_t;

  typedef struct packed {
    logic clr;
    logic push;
    logic abs;
    logic lo;
    logic hi;
  } mix_ctrl_t;

  typedef logic [31:0] top_oct_t [12];
  typedef logic [31:0] step_rom_t [128];
  typedef logic [15:0] target_rom_t [128];

  // top octave, notes 116..127, in Hz as Q16.16
  localparam top_oct_t TOP_OCTAVE = '{
    32'd435478536, 32'd461373440, 32'd488808132, 32'd517874176,
    32'd548668577, 32'd581294107, 32'd615859655, 32'd652480574,
    32'd691279090, 32'd732384689, 32'd775934547, 32'd822074013
  };

  function automatic step_rom_t build_step_rom();
    step_rom_t   rom;
    logic [63:0] e;
    logic [63:0] v;
    int          k;
    for (int n = 0; n < 128; n++) begin
      k = 127 - n;
      e = 64'(TOP_OCTAVE[11 - (k % 12)]);
      v = (e << 16) >> (k / 12);
      rom[n] = 32'(v / 64'(AUDIO_FS));
    end
    return rom;
  endfunction

  function automatic target_rom_t build_target_rom();
    target_rom_t rom;
    for (int n = 0; n < 128; n++) begin
      rom[n] = 16'((n * 65535 + 63) / 127);
    end
    return rom;
  endfunction

  localparam step_rom_t   STEP_ROM   = build_step_rom();
  localparam target_rom_t TARGET_ROM = build_target_rom();

endpackage

// File: rtl/pts_voice_mem.sv
// voice state memory with per-entry valid bits, one read and one write port
module pts_voice_mem (
  input  logic              clk,
  input  logic              rst,
  input  pts_pkg::mem_req_t req,
  input  pts_pkg::voice_t   wr_data,
  output pts_pkg::voice_t   rd_data
);

  pts_pkg::voice_t             mem [pts_pkg::VOICES];
  logic [pts_pkg::VOICES-1:0]  vbit;
  pts_pkg::voice_t             rd_q;
  logic                        rd_ok;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vbit  <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vbit[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_ok <= vbit[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

// File: rtl/pts_mix.sv
// triangle shaping, voice products, mix accumulator and output scaling
module pts_mix (
  input  logic                clk,
  input  logic                rst,
  input  pts_pkg::mix_ctrl_t  ctrl,
  input  logic [15:0]         wave_pos,
  input  logic [15:0]         level,
  input  logic [15:0]         gain,
  output logic                busy,
  output logic signed [15:0]  sample
);

  localparam int FULL_W = pts_pkg::ACC_W + 16;
  localparam int MAG_W  = FULL_W - pts_pkg::SCALE_SHIFT;

  logic signed [17:0]              tw;
  logic signed [15:0]              tri_val;
  logic signed [31:0]              prod;
  logic                            pvld;
  logic signed [pts_pkg::ACC_W-1:0] acc;
  logic [pts_pkg::ACC_W-1:0]       mag;
  logic                            neg;
  logic [31:0]                     p_lo;
  logic [pts_pkg::ACC_W-1:0]       p_hi;
  logic [FULL_W-1:0]               full;
  logic [MAG_W-1:0]                mag_s;

  always_comb begin
    if (wave_pos[15]) begin
      tw = 18'sd98303 - $signed({1'b0, wave_pos, 1'b0});
    end else begin
      tw = $signed({1'b0, wave_pos, 1'b0}) - 18'sd32768;
    end
  end

  assign tri_val = tw[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= 1'b0;
    end else begin
      pvld <= ctrl.push;
    end
  end

  always_ff @(posedge clk) begin
    prod <= tri_val * $signed({1'b0, level});
    if (ctrl.clr) begin
      acc <= '0;
    end else if (pvld) begin
      acc <= acc + pts_pkg::ACC_W'(prod);
    end
    if (ctrl.abs) begin
      neg <= acc[pts_pkg::ACC_W-1];
      mag <= acc[pts_pkg::ACC_W-1] ? unsigned'(-acc) : unsigned'(acc);
    end
    if (ctrl.lo) begin
      p_lo <= mag[15:0] * gain;
    end
    if (ctrl.hi) begin
      p_hi <= mag[pts_pkg::ACC_W-1:16] * gain;
    end
  end

  assign busy  = pvld;
  assign full  = {p_hi, 16'b0} + FULL_W'(p_lo);
  assign mag_s = full[FULL_W-1:pts_pkg::SCALE_SHIFT];

  always_comb begin
    if (!neg) begin
      sample = (mag_s > MAG_W'(32767)) ? 16'sh7fff : $signed(mag_s[15:0]);
    end else begin
      sample = (mag_s > MAG_W'(32768)) ? 16'sh8000 : $signed(16'(-mag_s[15:0]));
    end
  end

endmodule

// File: rtl/polyphonic_triangle_synth.sv
// top level of the polyphonic triangle synth
//
// Commands enter on req_valid/req_ready with func, note and velocity. A sample
// tick returns one item on sample_valid/sample_ready; note on, note off and
// all notes off return nothing. Register writes (cfg_we, cfg_index, cfg_data)
// take effect at once and are meant for when the block is idle.
// One command is worked at a time: every command sweeps the voice memory,
// one voice per cycle, through a read-modify-write pipeline, so the voice
// count sets the time. A tick goes through the sweep, the drain of the
// multiply-accumulate, the magnitude step and the gain scaling with two
// narrow products, then the output load. A note on reads and writes back
// the chosen voice after the drain; note off and all off end with the drain.
// The finished sample sits in an output register, so the next command is
// taken while it waits; a tick that finishes while the register is still
// full holds until the receiver takes the old sample.
// Reset clears the registers to their defaults and marks every voice empty
// at once through per-voice valid bits; no clearing pass is needed.
module polyphonic_triangle_synth (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         func,
  input  logic [6:0]         note,
  input  logic [6:0]         velocity,
  output logic               sample_valid,
  input  logic               sample_ready,
  output logic signed [15:0] sample
);

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_ON_RD,
    S_ON_WR,
    S_ABS,
    S_LO,
    S_HI,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    KIND_RETRIG,
    KIND_FREE,
    KIND_STEAL
  } kind_t;

  state_t             state;
  pts_pkg::vidx_t     cnt;
  pts_pkg::func_t     func_q;
  logic [6:0]         note_q;
  logic [6:0]         vel_q;

  logic [15:0]        attack_step;
  logic [15:0]        release_step;
  logic [15:0]        output_gain;

  pts_pkg::mem_req_t  req;
  pts_pkg::voice_t    wr_data;
  pts_pkg::voice_t    rd_data;
  logic               rd_vld;
  pts_pkg::vidx_t     rd_idx;

  logic               act;
  logic [16:0]        att_sum;
  logic [15:0]        lv_next;
  logic [31:0]        phase_next;

  logic               t_vld;
  logic               t_act;
  logic [15:0]        t_x;
  logic [15:0]        t_lv;

  logic               hit_found;
  logic               free_found;
  pts_pkg::vidx_t     hit_idx;
  pts_pkg::vidx_t     free_idx;
  pts_pkg::vidx_t     min_idx;
  logic [15:0]        min_lv;
  logic               hit_cond;
  logic               free_cond;
  logic               first;

  pts_pkg::vidx_t     sel_idx;
  pts_pkg::vidx_t     sel_idx_next;
  kind_t              sel_kind;
  kind_t              sel_kind_next;

  pts_pkg::mix_ctrl_t mix_ctrl;
  logic               mix_busy;
  logic signed [15:0] mix_sample;

  assign req_ready = (state == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step  <= 16'd297;
      release_step <= 16'd74;
      output_gain  <= 16'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pts_pkg::REG_ATTACK:  attack_step  <= cfg_data;
        pts_pkg::REG_RELEASE: release_step <= cfg_data;
        pts_pkg::REG_GAIN:    output_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // envelope and phase for the voice just read
  always_comb begin
    act     = (rd_data.level != 16'd0) || (rd_data.target != 16'd0);
    att_sum = {1'b0, rd_data.level} + {1'b0, attack_step};
    if (rd_data.level < rd_data.target) begin
      lv_next = (att_sum > {1'b0, rd_data.target}) ? rd_data.target : att_sum[15:0];
    end else if (rd_data.level > rd_data.target) begin
      lv_next = (rd_data.level > release_step) ? rd_data.level - release_step : 16'd0;
    end else begin
      lv_next = rd_data.level;
    end
    phase_next = rd_data.phase + rd_data.step;
  end

  // voice choice for note on
  always_comb begin
    if (hit_found) begin
      sel_idx_next  = hit_idx;
      sel_kind_next = KIND_RETRIG;
    end else if (free_found) begin
      sel_idx_next  = free_idx;
      sel_kind_next = KIND_FREE;
    end else begin
      sel_idx_next  = min_idx;
      sel_kind_next = KIND_STEAL;
    end
  end

  // memory port control and write-back data
  always_comb begin
    req.rd_en   = (state == S_SWEEP) || (state == S_ON_RD);
    req.rd_addr = (state == S_ON_RD) ? sel_idx_next : cnt;
    req.wr_en   = 1'b0;
    req.wr_addr = rd_idx;
    wr_data     = rd_data;
    if (state == S_ON_WR) begin
      req.wr_en      = 1'b1;
      req.wr_addr    = sel_idx;
      wr_data.target = pts_pkg::TARGET_ROM[vel_q];
      case (sel_kind)
        KIND_FREE: begin
          wr_data.note  = note_q;
          wr_data.step  = pts_pkg::STEP_ROM[note_q];
          wr_data.gate  = 1'b1;
          wr_data.phase = 32'd0;
        end
        KIND_STEAL: begin
          wr_data.note = note_q;
          wr_data.step = pts_pkg::STEP_ROM[note_q];
          wr_data.gate = 1'b1;
        end
        default: ;
      endcase
    end else if (rd_vld) begin
      unique case (func_q)
        pts_pkg::FUNC_NOTE_ON: ;
        pts_pkg::FUNC_NOTE_OFF: begin
          req.wr_en = 1'b1;
          if (rd_data.gate && (rd_data.note == note_q)) begin
            wr_data.gate   = 1'b0;
            wr_data.target = 16'd0;
          end
        end
        pts_pkg::FUNC_ALL_OFF: begin
          req.wr_en      = 1'b1;
          wr_data.gate   = 1'b0;
          wr_data.target = 16'd0;
        end
        pts_pkg::FUNC_TICK: begin
          req.wr_en = act;
          wr_data.level = lv_next;
          wr_data.phase = phase_next;
        end
      endcase
    end
  end

  pts_voice_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // note-on search over the sweep
  assign hit_cond  = rd_data.gate && (rd_data.note == note_q);
  assign free_cond = !rd_data.gate && (rd_data.level == 16'd0);
  assign first     = (rd_idx == '0);

  always_ff @(posedge clk) begin
    if (rd_vld && (func_q == pts_pkg::FUNC_NOTE_ON)) begin
      if (first) begin
        hit_found  <= hit_cond;
        hit_idx    <= rd_idx;
        free_found <= free_cond;
        free_idx   <= rd_idx;
        min_idx    <= rd_idx;
        min_lv     <= rd_data.level;
      end else begin
        if (hit_cond && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= rd_idx;
        end
        if (free_cond && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
        if (rd_data.level < min_lv) begin
          min_idx <= rd_idx;
          min_lv  <= rd_data.level;
        end
      end
    end
  end

  // tick stage between memory and mixer
  always_ff @(posedge clk) begin
    t_x   <= phase_next[31:16];
    t_lv  <= lv_next;
    t_act <= act;
  end

  always_comb begin
    mix_ctrl.clr  = (state == S_IDLE) && req_valid;
    mix_ctrl.push = t_vld && t_act;
    mix_ctrl.abs  = (state == S_ABS);
    mix_ctrl.lo   = (state == S_LO);
    mix_ctrl.hi   = (state == S_HI);
  end

  pts_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mix_ctrl),
    .wave_pos (t_x),
    .level    (t_lv),
    .gain     (output_gain),
    .busy     (mix_busy),
    .sample   (mix_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      rd_vld       <= 1'b0;
      t_vld        <= 1'b0;
      sample_valid <= 1'b0;
    end else begin
      rd_vld <= (state == S_SWEEP);
      t_vld  <= rd_vld && (func_q == pts_pkg::FUNC_TICK);
      if (sample_valid && sample_ready && (state != S_OUT)) begin
        sample_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            func_q <= pts_pkg::func_t'(func);
            note_q <= note;
            vel_q  <= velocity;
            cnt    <= '0;
            state  <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          rd_idx <= cnt;
          cnt    <= cnt + 1'b1;
          if (cnt == pts_pkg::LAST_VOICE) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_vld && !t_vld && !mix_busy) begin
            if (func_q == pts_pkg::FUNC_NOTE_ON) begin
              state <= S_ON_RD;
            end else if (func_q == pts_pkg::FUNC_TICK) begin
              state <= S_ABS;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_ON_RD: begin
          sel_idx  <= sel_idx_next;
          sel_kind <= sel_kind_next;
          state    <= S_ON_WR;
        end
        S_ON_WR: state <= S_IDLE;
        S_ABS:   state <= S_LO;
        S_LO:    state <= S_HI;
        S_HI:    state <= S_OUT;
        S_OUT: begin
          if (!sample_valid || sample_ready) begin
            sample_valid <= 1'b1;
            sample       <= mix_sample;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PTS_ASSERT_IMP(a_idle_empty, req_ready, !rd_vld && !t_vld && !mix_busy, "pipeline busy in idle")
  `PTS_ASSERT_IMP(a_out_from_fin, $rose(sample_valid), $past(state) == S_OUT, "stray sample")
  `PTS_ASSERT_IMP(a_claim_after_read, (state == S_ON_WR), $past(state) == S_ON_RD, "claim without read")
  `PTS_ASSERT_IMP(a_search_no_write, rd_vld && (func_q == pts_pkg::FUNC_NOTE_ON), !req.wr_en, "write in search")

endmodule
